// ===== sv/crs_pkg.sv =====
// shared types and constants of the catmull-rom segment sampler
// no dependencies
`default_nettype none

package crs_pkg;

    localparam int MAX_SEGMENTS = 63;
    localparam int COORD_W      = 32;
    localparam int SPACING_W    = 31;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd6554;
    localparam int IDX_W        = 6;
    localparam int N_W          = $clog2(MAX_SEGMENTS + 1);
    localparam int N3_W         = 3 * N_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int SQ_CHUNKS    = (DIFF_W + N_W - 1) / N_W;
    localparam int STEP_W       = $clog2(2 * SQ_CHUNKS + 1);
    localparam int COEF_W       = 36;
    localparam int NUM_W        = 62;
    localparam int DVD_W        = 61;
    localparam int QUO_W        = 31;
    localparam int REM_W        = 36;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
    } pts_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [IDX_W-1:0]          sample_index;
        logic                      last_sample;
        logic                      count_clamped;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/crs_core.sv =====
// sequencer and shared datapath: length, segment count, cubic evaluation
// depends on crs_pkg
`default_nettype none

module crs_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire crs_pkg::pts_t                   pts,
    input  wire logic [crs_pkg::SPACING_W-1:0]   spacing,
    output logic                                 busy,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output crs_pkg::res_t                        res
);

    localparam int NW = crs_pkg::N_W;
    localparam int SW = crs_pkg::STEP_W;
    localparam int CW = crs_pkg::COEF_W;
    localparam int MW = crs_pkg::NUM_W;
    localparam int RW = crs_pkg::REM_W;
    localparam int DW = crs_pkg::DVD_W;
    localparam int QW = crs_pkg::QUO_W;
    localparam int SQC = crs_pkg::SQ_CHUNKS;
    localparam int SPACING_W_L = crs_pkg::SPACING_W;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_MUL, S_SQ_ACC, S_ROOT, S_LDIV_CHK, S_LDIV, S_NSET,
        S_POW_MUL, S_POW_ACC, S_COEF, S_PRE_MUL, S_PRE_ACC, S_EV_MUL,
        S_EV_ACC, S_DIV_CHK, S_DIV, S_EMIT
    } state_t;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] d;
    } coef_t;

    function automatic coef_t calc_coef(input logic signed [31:0] p0,
                                        input logic signed [31:0] p1,
                                        input logic signed [31:0] p2,
                                        input logic signed [31:0] p3);
        logic signed [CW-1:0] q0;
        logic signed [CW-1:0] q1;
        logic signed [CW-1:0] q2;
        logic signed [CW-1:0] q3;
        coef_t r;
        q0 = CW'(p0);
        q1 = CW'(p1);
        q2 = CW'(p2);
        q3 = CW'(p3);
        r.a = q1 <<< 1;
        r.b = q2 - q0;
        r.c = (q0 <<< 1) - ((q1 <<< 2) + q1) + (q2 <<< 2) - q3;
        r.d = ((q1 <<< 1) + q1) - ((q2 <<< 1) + q2) + q3 - q0;
        return r;
    endfunction

    state_t                 state_reg;
    crs_pkg::pts_t          pts_reg;
    logic [32:0]            ax_reg;
    logic [32:0]            ay_reg;
    logic [crs_pkg::SQ_W-1:0] acc_reg;
    logic [RW-1:0]          rem_reg;
    logic [32:0]            root_reg;
    logic [5:0]             cnt_reg;
    logic [SW-1:0]          step_reg;
    logic                   axis_reg;
    logic signed [MW-1:0]   prod_reg;
    logic [NW-1:0]          n_reg;
    logic                   clamp_reg;
    logic [crs_pkg::N3_W-1:0] n3_reg;
    coef_t                  cf_reg [2];
    logic signed [MW-1:0]   cn_reg [2];
    logic signed [MW-1:0]   bnn_reg [2];
    logic signed [MW-1:0]   annn_reg [2];
    logic signed [MW-1:0]   t_reg;
    logic [NW-1:0]          j_reg;
    logic [DW-1:0]          dvd_reg;
    logic [QW-1:0]          quo_reg;
    logic                   neg_reg;
    logic signed [31:0]     px_reg;
    logic signed [31:0]     py_reg;

    logic signed [32:0]     dx;
    logic signed [32:0]     dy;
    logic [SW-1:0]          sq_k;
    logic [32:0]            sq_src;
    logic signed [MW-1:0]   mul_a;
    logic [NW-1:0]          mul_b;
    logic signed [MW+NW:0]  mul_full;
    logic [RW-1:0]          root_rsh;
    logic [RW-1:0]          root_trial;
    logic                   root_ge;
    logic [32:0]            root_nx;
    logic [SPACING_W_L-1:0] sp_eff;
    logic [30:0]            dvs;
    logic [RW-1:0]          div_rsh;
    logic                   div_ge;
    logic [QW-1:0]          quo_nx;
    logic signed [MW-1:0]   v_sum;
    logic [DW-1:0]          v_mag;
    logic [NW-1:0]          q_len;
    logic signed [31:0]     div_val;
    coef_t                  cf_x;
    coef_t                  cf_y;
    coef_t                  cf_cur;

    assign dx = 33'(pts.p2_x) - 33'(pts.p1_x);
    assign dy = 33'(pts.p2_y) - 33'(pts.p1_y);
    assign sq_k = (step_reg < SW'(SQC)) ? step_reg : step_reg - SW'(SQC);
    assign sq_src = (step_reg < SW'(SQC)) ? ax_reg : ay_reg;
    assign cf_x = calc_coef(pts_reg.p0_x, pts_reg.p1_x, pts_reg.p2_x, pts_reg.p3_x);
    assign cf_y = calc_coef(pts_reg.p0_y, pts_reg.p1_y, pts_reg.p2_y, pts_reg.p3_y);
    assign cf_cur = cf_reg[axis_reg];

    // shared multiplier: wide signed operand times a narrow unsigned one
    always_comb
    begin
        mul_a = prod_reg;
        mul_b = n_reg;
        case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = MW'(sq_src);
                mul_b = NW'(sq_src >> (NW * sq_k));
            end
            S_POW_MUL:
            begin
                mul_a = (step_reg == '0) ? MW'(n_reg) : prod_reg;
            end
            S_PRE_MUL:
            begin
                case (step_reg)
                    SW'(0):  mul_a = MW'(cf_cur.c);
                    SW'(1):  mul_a = MW'(cf_cur.b);
                    SW'(3):  mul_a = MW'(cf_cur.a);
                    default: mul_a = prod_reg;
                endcase
            end
            S_EV_MUL:
            begin
                mul_a = (step_reg == '0) ? MW'(cf_cur.d) : t_reg;
                mul_b = j_reg;
            end
            default:
            begin
                mul_a = prod_reg;
                mul_b = n_reg;
            end
        endcase
    end

    assign mul_full = mul_a * $signed({1'b0, mul_b});

    // square root digit step
    assign root_rsh = {rem_reg[RW-3:0], acc_reg[crs_pkg::SQ_W-1 -: 2]};
    assign root_trial = RW'({root_reg, 2'b01});
    assign root_ge = root_rsh >= root_trial;
    assign root_nx = {root_reg[31:0], root_ge};

    // shared restoring divider step
    assign sp_eff = (spacing == '0) ? SPACING_W_L'(1) : spacing;
    assign dvs = (state_reg == S_LDIV || state_reg == S_LDIV_CHK) ?
                 31'(sp_eff) : 31'({n3_reg, 1'b0});
    assign div_rsh = {rem_reg[RW-2:0], dvd_reg[DW-1]};
    assign div_ge = div_rsh >= RW'(dvs);
    assign quo_nx = {quo_reg[QW-2:0], div_ge};

    assign v_sum = prod_reg + annn_reg[axis_reg] + MW'(n3_reg);
    assign v_mag = v_sum[MW-1] ? DW'(~v_sum) : DW'(v_sum);
    assign q_len = quo_reg[NW-1:0];
    assign div_val = neg_reg ? ~{1'b0, quo_nx} : {1'b0, quo_nx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        pts_reg <= pts;
                        ax_reg <= dx[32] ? 33'(-dx) : 33'(dx);
                        ay_reg <= dy[32] ? 33'(-dy) : 33'(dy);
                        acc_reg <= '0;
                        step_reg <= '0;
                        clamp_reg <= 1'b0;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL:
                begin
                    prod_reg <= mul_full[MW-1:0];
                    state_reg <= S_SQ_ACC;
                end
                S_SQ_ACC:
                begin
                    acc_reg <= acc_reg + (crs_pkg::SQ_W'(prod_reg) << (NW * sq_k));
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(2 * SQC - 1))
                    begin
                        rem_reg <= '0;
                        root_reg <= '0;
                        cnt_reg <= 6'd32;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_ROOT:
                begin
                    root_reg <= root_nx;
                    acc_reg <= acc_reg << 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        rem_reg <= RW'(root_nx >> NW);
                        dvd_reg <= DW'(root_nx) << (DW - NW);
                        state_reg <= S_LDIV_CHK;
                    end
                    else
                    begin
                        rem_reg <= root_ge ? root_rsh - root_trial : root_rsh;
                    end
                end
                S_LDIV_CHK:
                begin
                    quo_reg <= '0;
                    cnt_reg <= 6'(NW);
                    step_reg <= '0;
                    if (rem_reg >= RW'(dvs))
                    begin
                        n_reg <= NW'(crs_pkg::MAX_SEGMENTS);
                        clamp_reg <= 1'b1;
                        state_reg <= S_POW_MUL;
                    end
                    else
                    begin
                        state_reg <= S_LDIV;
                    end
                end
                S_LDIV:
                begin
                    rem_reg <= div_ge ? div_rsh - RW'(dvs) : div_rsh;
                    quo_reg <= quo_nx;
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_NSET;
                    end
                end
                S_NSET:
                begin
                    if (q_len > NW'(crs_pkg::MAX_SEGMENTS))
                    begin
                        n_reg <= NW'(crs_pkg::MAX_SEGMENTS);
                        clamp_reg <= 1'b1;
                    end
                    else if (q_len < NW'(3))
                    begin
                        n_reg <= NW'(3);
                    end
                    else
                    begin
                        n_reg <= q_len;
                    end
                    state_reg <= S_POW_MUL;
                end
                S_POW_MUL:
                begin
                    prod_reg <= mul_full[MW-1:0];
                    state_reg <= S_POW_ACC;
                end
                S_POW_ACC:
                begin
                    if (step_reg == '0)
                    begin
                        step_reg <= SW'(1);
                        state_reg <= S_POW_MUL;
                    end
                    else
                    begin
                        n3_reg <= prod_reg[crs_pkg::N3_W-1:0];
                        state_reg <= S_COEF;
                    end
                end
                S_COEF:
                begin
                    cf_reg[0] <= cf_x;
                    cf_reg[1] <= cf_y;
                    axis_reg <= 1'b0;
                    step_reg <= '0;
                    state_reg <= S_PRE_MUL;
                end
                S_PRE_MUL:
                begin
                    prod_reg <= mul_full[MW-1:0];
                    state_reg <= S_PRE_ACC;
                end
                S_PRE_ACC:
                begin
                    case (step_reg)
                        SW'(0):  cn_reg[axis_reg] <= prod_reg;
                        SW'(2):  bnn_reg[axis_reg] <= prod_reg;
                        SW'(5):  annn_reg[axis_reg] <= prod_reg;
                        default: ;
                    endcase
                    if (step_reg == SW'(5))
                    begin
                        step_reg <= '0;
                        axis_reg <= ~axis_reg;
                        if (axis_reg)
                        begin
                            j_reg <= '0;
                            state_reg <= S_EV_MUL;
                        end
                        else
                        begin
                            state_reg <= S_PRE_MUL;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                        state_reg <= S_PRE_MUL;
                    end
                end
                S_EV_MUL:
                begin
                    prod_reg <= mul_full[MW-1:0];
                    state_reg <= S_EV_ACC;
                end
                S_EV_ACC:
                begin
                    case (step_reg)
                        SW'(0):
                        begin
                            t_reg <= prod_reg + cn_reg[axis_reg];
                            step_reg <= SW'(1);
                            state_reg <= S_EV_MUL;
                        end
                        SW'(1):
                        begin
                            t_reg <= prod_reg + bnn_reg[axis_reg];
                            step_reg <= SW'(2);
                            state_reg <= S_EV_MUL;
                        end
                        default:
                        begin
                            neg_reg <= v_sum[MW-1];
                            rem_reg <= RW'(v_mag >> QW);
                            dvd_reg <= v_mag << (DW - QW);
                            step_reg <= '0;
                            state_reg <= S_DIV_CHK;
                        end
                    endcase
                end
                S_DIV_CHK:
                begin
                    quo_reg <= '0;
                    cnt_reg <= 6'(QW);
                    if (rem_reg >= RW'(dvs))
                    begin
                        if (axis_reg)
                        begin
                            py_reg <= neg_reg ? SAT_MIN : SAT_MAX;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            px_reg <= neg_reg ? SAT_MIN : SAT_MAX;
                            state_reg <= S_EV_MUL;
                        end
                        axis_reg <= ~axis_reg;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= div_ge ? div_rsh - RW'(dvs) : div_rsh;
                    quo_reg <= quo_nx;
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        if (axis_reg)
                        begin
                            py_reg <= div_val;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            px_reg <= div_val;
                            state_reg <= S_EV_MUL;
                        end
                        axis_reg <= ~axis_reg;
                    end
                end
                S_EMIT:
                begin
                    if (res_ready)
                    begin
                        if (j_reg == n_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg <= j_reg + NW'(1);
                            step_reg <= '0;
                            state_reg <= S_EV_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = state_reg != S_IDLE;
    assign res_valid = state_reg == S_EMIT;
    assign res.point_x = px_reg;
    assign res.point_y = py_reg;
    assign res.sample_index = crs_pkg::IDX_W'(j_reg);
    assign res.last_sample = j_reg == n_reg;
    assign res.count_clamped = clamp_reg;

endmodule

`default_nettype wire

// ===== sv/catmull_rom_segment_sampler_top.sv =====
// top level of the catmull-rom segment sampler: stream ports, spacing register,
// output register; depends on crs_pkg and crs_core
//
// channel   dir  signals                          fields
// s_        in   s_tvalid s_tready s_tdata[255:0] control points p0..p3
// m_        out  m_tvalid m_tready m_tdata[71:0]  curve point, index
//                m_tlast m_tuser                  last sample, clamped flag
// cfg_      in   cfg_wr_en cfg_wr_data[30:0]      sample spacing
//
// each segment is set up first: square, root, divide, coefficients (the length divide is
// skipped when the early check clamps the count); then each sample takes two axes, each three
// passes through the shared multiplier, a range check and 31 divider steps (skipped when the axis
// saturates), and the emit state that hands the sample on
// s_tready is low from an accepted beat until the last sample enters the output register
// rst_n clears control state and loads the reset spacing of 6554
// m_tready low holds the output register and pauses the sequencer at the next sample
`default_nettype none

module catmull_rom_segment_sampler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [255:0] s_tdata,   // p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,    // point_x point_y sample_index, zero pad
    output logic             m_tlast,    // last_sample
    output logic             m_tuser,    // count_clamped
    input  wire logic        cfg_wr_en,
    input  wire logic [30:0] cfg_wr_data
);

    logic [crs_pkg::SPACING_W-1:0] spacing_reg;
    logic                          out_valid_reg;
    crs_pkg::res_t                 out_reg;
    crs_pkg::pts_t                 pts;
    crs_pkg::res_t                 res;
    logic                          busy;
    logic                          res_valid;
    logic                          res_ready;

    assign pts.p0_x = s_tdata[31:0];
    assign pts.p0_y = s_tdata[63:32];
    assign pts.p1_x = s_tdata[95:64];
    assign pts.p1_y = s_tdata[127:96];
    assign pts.p2_x = s_tdata[159:128];
    assign pts.p2_y = s_tdata[191:160];
    assign pts.p3_x = s_tdata[223:192];
    assign pts.p3_y = s_tdata[255:224];

    assign s_tready = !busy;
    assign res_ready = !out_valid_reg || m_tready;

    crs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && s_tready),
        .pts       (pts),
        .spacing   (spacing_reg),
        .busy      (busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= crs_pkg::SPACING_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                spacing_reg <= cfg_wr_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
                if (res_valid)
                begin
                    out_reg <= res;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_reg.sample_index, out_reg.point_y, out_reg.point_x};
    assign m_tlast = out_reg.last_sample;
    assign m_tuser = out_reg.count_clamped;

endmodule

`default_nettype wire

// ===== sv/crs_checker.sv =====
// port-level checks of the catmull-rom segment sampler, bound to the top level
// depends on crs_pkg and catmull_rom_segment_sampler_top
`default_nettype none

module crs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a segment is in progress");

    a_busy_mid_segment: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready before the last sample of a segment");

    a_min_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[69:64] >= 6'd3)
        else $error("segment shorter than three steps");

    a_clamp_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tuser |-> m_tdata[69:64] == 6'(crs_pkg::MAX_SEGMENTS))
        else $error("clamped segment does not end at the maximum count");

endmodule

bind catmull_rom_segment_sampler_top crs_checker u_crs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_catmull_rom_segment_sampler_top.sv =====
// testbench of catmull_rom_segment_sampler_top: directed and random segments,
// predicted sample points checked beat by beat; depends on crs_pkg and the rtl
`default_nettype none

module tb_catmull_rom_segment_sampler_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         cfg_wr_en;
    logic [30:0]  cfg_wr_data;

    catmull_rom_segment_sampler_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    crs_pkg::pts_t   segment_q[$];
    crs_pkg::res_t   sample_q[$];
    crs_pkg::pts_t   cur_seg;
    logic [30:0]     spacing_shadow;
    int              burst_left;
    int              gap_left;
    int              stall_left;
    int              stall_mode;
    int              idle_cycles;
    int              mismatches;
    int              segs_sent;
    int              samples_seen;
    int              clamped_seen;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [32:0] isqrt66(input logic [65:0] v);
        logic [67:0] rem;
        logic [33:0] root;
        logic [67:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            trial = {root, 2'b01};
            rem   = {rem[65:0], v[2*i+1], v[2*i]};
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = {root[32:0], 1'b1};
            end
            else
                root = {root[32:0], 1'b0};
        end
        return root[32:0];
    endfunction

    function automatic logic signed [31:0] curve_axis(input longint q0, input longint q1,
                                                      input longint q2, input longint q3,
                                                      input longint j, input longint n);
        longint a, b, c, d, n3, num, den, v, q;
        a   = 2 * q1;
        b   = q2 - q0;
        c   = 2 * q0 - 5 * q1 + 4 * q2 - q3;
        d   = -q0 + 3 * q1 - 3 * q2 + q3;
        n3  = n * n * n;
        num = a * n3 + b * j * n * n + c * j * j * n + d * j * j * j;
        den = 2 * n3;
        v   = num + n3;
        if (v >= 0)
            q = v / den;
        else
            q = -((-v + den - 1) / den);
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic queue_segment(input crs_pkg::pts_t p);
        segment_q = {segment_q, p};
    endtask

    task automatic predict_samples(input crs_pkg::pts_t p);
        longint        dx, dy;
        logic [65:0]   ax, ay, len2;
        logic [32:0]   seg_len;
        logic [32:0]   sp;
        logic [32:0]   nq;
        int            n;
        logic          clamped;
        crs_pkg::res_t r;
        dx   = longint'(p.p2_x) - longint'(p.p1_x);
        dy   = longint'(p.p2_y) - longint'(p.p1_y);
        ax   = 66'((dx < 0) ? -dx : dx);
        ay   = 66'((dy < 0) ? -dy : dy);
        len2 = ax * ax + ay * ay;
        seg_len = isqrt66(len2);
        sp   = (spacing_shadow == 0) ? 33'd1 : {2'b00, spacing_shadow};
        nq   = seg_len / sp;
        if (nq < 3)
            n = 3;
        else if (nq > crs_pkg::MAX_SEGMENTS)
            n = crs_pkg::MAX_SEGMENTS + 1;
        else
            n = int'(nq);
        clamped = 1'b0;
        if (n > crs_pkg::MAX_SEGMENTS)
        begin
            n       = crs_pkg::MAX_SEGMENTS;
            clamped = 1'b1;
        end
        for (int j = 0; j <= n; j++)
        begin
            r.point_x       = curve_axis(p.p0_x, p.p1_x, p.p2_x, p.p3_x, j, n);
            r.point_y       = curve_axis(p.p0_y, p.p1_y, p.p2_y, p.p3_y, j, n);
            r.sample_index  = j[crs_pkg::IDX_W-1:0];
            r.last_sample   = (j == n);
            r.count_clamped = clamped;
            sample_q = {sample_q, r};
        end
    endtask

    function automatic crs_pkg::pts_t make_pts(input logic [31:0] a0x, input logic [31:0] a0y,
                                               input logic [31:0] a1x, input logic [31:0] a1y,
                                               input logic [31:0] a2x, input logic [31:0] a2y,
                                               input logic [31:0] a3x, input logic [31:0] a3y);
        crs_pkg::pts_t p;
        p.p0_x = a0x; p.p0_y = a0y; p.p1_x = a1x; p.p1_y = a1y;
        p.p2_x = a2x; p.p2_y = a2y; p.p3_x = a3x; p.p3_y = a3y;
        return p;
    endfunction

    // inner points up to max_len (max 2^30-1) raw units apart per axis, outer points mostly random
    function automatic crs_pkg::pts_t random_segment(input longint max_len);
        crs_pkg::pts_t p;
        longint        lim, d;
        lim    = (max_len > 64'sd1073741823) ? 64'sd1073741823 : max_len;
        p.p0_x = $urandom;
        p.p0_y = $urandom;
        p.p3_x = $urandom;
        p.p3_y = $urandom;
        p.p1_x = $urandom_range(32'h7FFFFFFF, 0) - 32'sh40000000;
        p.p1_y = $urandom_range(32'h7FFFFFFF, 0) - 32'sh40000000;
        d = $urandom_range(lim[31:0], 0);
        p.p2_x = $urandom_range(1, 0) ? p.p1_x + d[31:0] : p.p1_x - d[31:0];
        d = $urandom_range(lim[31:0], 0);
        p.p2_y = $urandom_range(1, 0) ? p.p1_y + d[31:0] : p.p1_y - d[31:0];
        if ($urandom_range(7, 0) == 0)
        begin
            p.p0_x = p.p1_x;
            p.p3_y = p.p2_y;
        end
        return p;
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (segment_q.size() != 0 || s_tvalid || sample_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_spacing(input logic [30:0] v);
        @(posedge clk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= v;
        spacing_shadow <= v;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_samples(cur_seg);
                segs_sent = segs_sent + 1;
            end
            if (s_tvalid && !s_tready)
                s_tvalid <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (segment_q.size() != 0)
            begin
                cur_seg = segment_q.pop_front();
                s_tdata <= {cur_seg.p3_y, cur_seg.p3_x, cur_seg.p2_y, cur_seg.p2_x,
                            cur_seg.p1_y, cur_seg.p1_x, cur_seg.p0_y, cur_seg.p0_x};
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(6, 1);
                    gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 1);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern that switches between none, short and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(199, 0) == 0)
                stall_mode <= $urandom_range(2, 0);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if (stall_mode == 1 && $urandom_range(3, 0) == 0)
            begin
                stall_left <= $urandom_range(3, 0);
                m_tready   <= 1'b0;
            end
            else if (stall_mode == 2 && $urandom_range(9, 0) == 0)
            begin
                stall_left <= $urandom_range(120, 10);
                m_tready   <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // sample checker and watchdog
    always @(posedge clk)
    begin
        crs_pkg::res_t want;
        crs_pkg::res_t got;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                got.point_x       = m_tdata[31:0];
                got.point_y       = m_tdata[63:32];
                got.sample_index  = m_tdata[69:64];
                got.last_sample   = m_tlast;
                got.count_clamped = m_tuser;
                samples_seen = samples_seen + 1;
                if (m_tuser)
                    clamped_seen = clamped_seen + 1;
                if (sample_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected sample beat: x=%0d y=%0d j=%0d",
                                 got.point_x, got.point_y, got.sample_index);
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("sample mismatch: exp x=%0d y=%0d j=%0d last=%0b clamp=%0b",
                                     want.point_x, want.point_y, want.sample_index,
                                     want.last_sample, want.count_clamped);
                            $display("                 got x=%0d y=%0d j=%0d last=%0b clamp=%0b",
                                     got.point_x, got.point_y, got.sample_index,
                                     got.last_sample, got.count_clamped);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        logic [31:0] mx, mn;
        logic [30:0] sp;
        mx = 32'h7FFFFFFF;
        mn = 32'h80000000;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        spacing_shadow = crs_pkg::SPACING_RESET;
        idle_cycles    = 0;
        mismatches     = 0;
        segs_sent      = 0;
        samples_seen   = 0;
        clamped_seen   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset spacing: extremes, short, clamped, overflowing squares, saturation
        queue_segment(make_pts(0, 0, 0, 0, 0, 0, 0, 0));
        queue_segment(make_pts(mx, mx, mx, mx, mx, mx, mx, mx));
        queue_segment(make_pts(mn, mn, mn, mn, mn, mn, mn, mn));
        queue_segment(make_pts(mn, mn, mx, mx, mx, mx, mn, mn));
        queue_segment(make_pts(mx, mx, mn, mn, mn, mn, mx, mx));
        queue_segment(make_pts(0, 0, mn, mn, mx, mx, 0, 0));
        queue_segment(make_pts(mx, mn, mx, mn, mn, mx, mn, mx));
        queue_segment(make_pts(mn, mx, mx, 0, mx, 1, mn, mx));
        queue_segment(make_pts(0, 0, 0, 0, 6554 * 3, 0, 0, 0));
        queue_segment(make_pts(0, 0, 0, 0, 0, 6554 * 4 - 1, 0, 0));
        queue_segment(make_pts(1, 2, 5, 7, 5 + 6554 * 63, 7, 3, 4));
        queue_segment(make_pts(1, 2, 5, 7, 5 + 6554 * 64, 7, 3, 4));
        queue_segment(make_pts(-100, 50, 10, -10, -65536, 65536, 999, -999));
        queue_segment(make_pts(32'hFFFFFFFF, 1, 2, 3, 4, 5, 6, 7));
        wait_idle();

        // zero spacing acts as one
        write_spacing(31'd0);
        for (int i = 0; i < 6; i++)
            queue_segment(random_segment(8));
        wait_idle();

        write_spacing(31'd1);
        for (int i = 0; i < 5; i++)
            queue_segment(random_segment(10));
        queue_segment(make_pts(0, 0, 0, 0, 63, 0, 0, 0));
        wait_idle();

        // widest spacing: any content gives the minimum count
        write_spacing(31'h7FFFFFFF);
        for (int i = 0; i < 60; i++)
            queue_segment(make_pts($urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom, $urandom));
        wait_idle();

        for (int ph = 0; ph < 2; ph++)
        begin
            sp = (ph == 0) ? 31'($urandom_range(1 << 20, 1 << 10))
                           : 31'($urandom_range(1000, 2));
            write_spacing(sp);
            for (int i = 0; i < 150; i++)
            begin
                if ($urandom_range(39, 0) == 0)
                    queue_segment(random_segment(64'sd1073741823));
                else
                    queue_segment(random_segment(longint'(sp) * 6));
            end
            wait_idle();
        end

        $display("covered %0d segments over six spacing settings, %0d sample beats",
                 segs_sent, samples_seen);
        $display("%0d beats from clamped segments, %0d mismatches", clamped_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/crs_pkg.sv
sv/crs_core.sv
sv/catmull_rom_segment_sampler_top.sv
sv/crs_checker.sv
tb/sv/tb_catmull_rom_segment_sampler_top.sv
